// ===== rtl/core/assert_macros.svh =====
// shared assertion macros for the data stack unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/core/fdsu_pkg.sv =====
`default_nettype none

package fdsu_pkg;

  // default number of stack entries
  localparam int unsigned STACK_DEPTH_DEF = 64;

  // fixed field widths
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned MODE_W  = 5;
  localparam int unsigned DEPTH_W = 7;

  typedef logic [MODE_W-1:0] mode_t;

  // primitive codes
  localparam mode_t OP_LIT     = 5'd0;
  localparam mode_t OP_DUP     = 5'd1;
  localparam mode_t OP_DROP    = 5'd2;
  localparam mode_t OP_SWAP    = 5'd3;
  localparam mode_t OP_OVER    = 5'd4;
  localparam mode_t OP_ZERO    = 5'd5;
  localparam mode_t OP_ONE     = 5'd6;
  localparam mode_t OP_ADD     = 5'd7;
  localparam mode_t OP_SUB     = 5'd8;
  localparam mode_t OP_MUL     = 5'd9;
  localparam mode_t OP_DIV     = 5'd10;
  localparam mode_t OP_MOD     = 5'd11;
  localparam mode_t OP_EQ      = 5'd12;
  localparam mode_t OP_NE      = 5'd13;
  localparam mode_t OP_GT      = 5'd14;
  localparam mode_t OP_GE      = 5'd15;
  localparam mode_t OP_LT      = 5'd16;
  localparam mode_t OP_LE      = 5'd17;
  localparam mode_t OP_ZEQ     = 5'd18;
  localparam mode_t OP_ZNE     = 5'd19;
  localparam mode_t OP_ZGT     = 5'd20;
  localparam mode_t OP_ZLT     = 5'd21;
  localparam mode_t OP_ZBRANCH = 5'd22;
  localparam mode_t OP_BRANCH  = 5'd23;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_UNDER = 2'd1,
    STAT_OVER  = 2'd2,
    STAT_DIVZ  = 2'd3
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_FILL,
    ST_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic div_start;
    logic div_commit;
    logic fill;
    logic publish;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic fault;
    logic is_div;
    logic refill;
    logic div_done;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/fdsu_divider.sv =====
`default_nettype none

`include "assert_macros.svh"

module fdsu_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        is_mod,
  input  logic [fdsu_pkg::DATA_W-1:0] dividend,
  input  logic [fdsu_pkg::DATA_W-1:0] divisor,
  output logic                        done,
  output logic [fdsu_pkg::DATA_W-1:0] result
);
  import fdsu_pkg::*;

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic              neg_q;
  logic              neg_r;
  logic              mod_sel;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;

  // one restoring step: shift in next dividend bit, try subtract
  assign rem_sh = {rem, quo[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  // control of the iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // magnitudes and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      quo     <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
      dvs     <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
      neg_q   <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      neg_r   <= dividend[DATA_W-1];
      mod_sel <= is_mod;
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  // sign correction, truncation toward zero
  always_comb begin
    if (mod_sel) begin
      result = neg_r ? (DATA_W'(0) - rem) : rem;
    end else begin
      result = neg_q ? (DATA_W'(0) - quo) : quo;
    end
  end

  `ASSERT_NEXT(a_start_busy, clk, rst, start, busy && !done)

endmodule

`default_nettype wire

// ===== rtl/core/fdsu_datapath.sv =====
`default_nettype none

`include "assert_macros.svh"

module fdsu_datapath #(
  parameter int unsigned STACK_DEPTH = fdsu_pkg::STACK_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  fdsu_pkg::dp_cmd_t                   cmd,
  output fdsu_pkg::dp_stat_t                  stat,
  input  logic [fdsu_pkg::MODE_W-1:0]         mode,
  input  logic signed [fdsu_pkg::DATA_W-1:0]  literal,
  output logic signed [fdsu_pkg::DATA_W-1:0]  top,
  output logic signed [fdsu_pkg::DATA_W-1:0]  second,
  output logic [fdsu_pkg::DEPTH_W-1:0]        depth,
  output logic                                branch_taken,
  output logic [1:0]                          status
);
  import fdsu_pkg::*;

  localparam int unsigned CNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned MEM_WORDS = (STACK_DEPTH > 2) ? STACK_DEPTH - 2 : 1;
  localparam int unsigned ADDR_W    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  // latched item
  mode_t             op;
  logic [DATA_W-1:0] lit;

  // top two entries in registers, the rest in memory
  logic [DATA_W-1:0] tos;
  logic [DATA_W-1:0] nos;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] mem [MEM_WORDS];
  logic [DATA_W-1:0] rdata;
  logic [CNT_W-1:0]  wr_ptr;
  logic [CNT_W-1:0]  rd_ptr;

  // per-item result flags
  status_t           res_status;
  logic              res_taken;

  // decode
  logic              is_push;
  logic              is_binop;
  logic              is_ztest;
  logic              is_divop;
  logic              pops;
  logic [1:0]        need;
  status_t           chk;
  logic [DATA_W-1:0] push_val;
  logic [DATA_W-1:0] alu_res;
  logic [DATA_W-1:0] zt_res;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] div_res;
  logic              div_done;
  logic              apply;

  assign is_push  = (op == OP_LIT) || (op == OP_DUP) || (op == OP_OVER) ||
                    (op == OP_ZERO) || (op == OP_ONE);
  assign is_binop = (op >= OP_ADD) && (op <= OP_LE);
  assign is_ztest = (op >= OP_ZEQ) && (op <= OP_ZLT);
  assign is_divop = (op == OP_DIV) || (op == OP_MOD);
  assign pops     = is_binop || (op == OP_DROP) || (op == OP_ZBRANCH);

  // entries an op needs
  always_comb begin
    if (is_binop || (op == OP_SWAP) || (op == OP_OVER)) begin
      need = 2'd2;
    end else if (is_ztest || (op == OP_DUP) || (op == OP_DROP) || (op == OP_ZBRANCH)) begin
      need = 2'd1;
    end else begin
      need = 2'd0;
    end
  end

  // underflow before overflow before divide by zero
  always_comb begin
    if (cnt < CNT_W'(need)) begin
      chk = STAT_UNDER;
    end else if (is_push && (cnt == CNT_W'(STACK_DEPTH))) begin
      chk = STAT_OVER;
    end else if (is_divop && (tos == '0)) begin
      chk = STAT_DIVZ;
    end else begin
      chk = STAT_OK;
    end
  end

  assign stat.fault    = (chk != STAT_OK);
  assign stat.is_div   = is_divop;
  assign stat.refill   = pops && (cnt >= CNT_W'(3));
  assign stat.div_done = div_done;

  assign apply = cmd.exec && (chk == STAT_OK) && !is_divop;

  // value pushed
  always_comb begin
    case (op)
      OP_LIT:  push_val = lit;
      OP_DUP:  push_val = tos;
      OP_OVER: push_val = nos;
      OP_ONE:  push_val = DATA_W'(1);
      default: push_val = '0;
    endcase
  end

  // binary ops as second op top
  assign prod = nos * tos;

  always_comb begin
    case (op)
      OP_ADD:  alu_res = nos + tos;
      OP_SUB:  alu_res = nos - tos;
      OP_MUL:  alu_res = prod;
      OP_EQ:   alu_res = DATA_W'(nos == tos);
      OP_NE:   alu_res = DATA_W'(nos != tos);
      OP_GT:   alu_res = DATA_W'($signed(nos) > $signed(tos));
      OP_GE:   alu_res = DATA_W'($signed(nos) >= $signed(tos));
      OP_LT:   alu_res = DATA_W'($signed(nos) < $signed(tos));
      OP_LE:   alu_res = DATA_W'($signed(nos) <= $signed(tos));
      default: alu_res = '0;
    endcase
  end

  // zero tests on the top
  always_comb begin
    case (op)
      OP_ZEQ:  zt_res = DATA_W'(tos == '0);
      OP_ZNE:  zt_res = DATA_W'(tos != '0);
      OP_ZGT:  zt_res = DATA_W'(!tos[DATA_W-1] && (tos != '0));
      OP_ZLT:  zt_res = DATA_W'(tos[DATA_W-1]);
      default: zt_res = '0;
    endcase
  end

  fdsu_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .is_mod   (op == OP_MOD),
    .dividend (nos),
    .divisor  (tos),
    .done     (div_done),
    .result   (div_res)
  );

  // stack depth counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (apply && is_push) begin
      cnt <= cnt + 1'b1;
    end else if ((apply && pops) || cmd.div_commit) begin
      cnt <= cnt - 1'b1;
    end
  end

  // item latch and result flags
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= mode;
      lit <= literal;
    end
    if (cmd.exec) begin
      res_status <= chk;
      res_taken  <= (chk == STAT_OK) &&
                    ((op == OP_BRANCH) || ((op == OP_ZBRANCH) && (tos == '0)));
    end
  end

  // top two registers
  always_ff @(posedge clk) begin
    if (apply) begin
      if (is_push) begin
        tos <= push_val;
        nos <= tos;
      end else if (op == OP_SWAP) begin
        tos <= nos;
        nos <= tos;
      end else if (is_ztest) begin
        tos <= zt_res;
      end else if (is_binop) begin
        tos <= alu_res;
      end else if ((op == OP_DROP) || (op == OP_ZBRANCH)) begin
        tos <= nos;
      end
    end else if (cmd.div_commit) begin
      tos <= div_res;
    end else if (cmd.fill) begin
      nos <= rdata;
    end
  end

  // spill below the top two, refill from the entry under them
  assign wr_ptr = cnt - CNT_W'(2);
  assign rd_ptr = cnt - CNT_W'(3);

  always_ff @(posedge clk) begin
    if (apply && is_push && (cnt >= CNT_W'(2))) begin
      mem[wr_ptr[ADDR_W-1:0]] <= nos;
    end
    rdata <= mem[rd_ptr[ADDR_W-1:0]];
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      top          <= (cnt >= CNT_W'(1)) ? $signed(tos) : '0;
      second       <= (cnt >= CNT_W'(2)) ? $signed(nos) : '0;
      depth        <= DEPTH_W'(cnt);
      branch_taken <= res_taken;
      status       <= res_status;
    end
  end

  `ASSERT_IMPLIES(a_depth_bound, clk, rst, 1'b1, cnt <= CNT_W'(STACK_DEPTH))
  `ASSERT_NEXT(a_fault_keeps_depth, clk, rst, cmd.exec && stat.fault, $stable(cnt))

endmodule

`default_nettype wire

// ===== rtl/core/fdsu_control.sv =====
`default_nettype none

`include "assert_macros.svh"

module fdsu_control (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output fdsu_pkg::dp_cmd_t  cmd,
  input  fdsu_pkg::dp_stat_t stat
);
  import fdsu_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   out_valid_next;

  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.fault) begin
          state_next = ST_DONE;
        end else if (stat.is_div) begin
          state_next = ST_DIV;
        end else if (stat.refill) begin
          state_next = ST_FILL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_next = stat.refill ? ST_FILL : ST_DONE;
        end
      end
      ST_FILL: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_EXEC: begin
        cmd.exec      = 1'b1;
        cmd.div_start = !stat.fault && stat.is_div;
      end
      ST_DIV: begin
        cmd.div_commit = stat.div_done;
      end
      ST_FILL: begin
        cmd.fill = 1'b1;
      end
      ST_DONE: begin
        cmd.publish = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // result beat held until taken
  always_comb begin
    if (cmd.publish) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `ASSERT_IMPLIES(a_one_cmd, clk, rst, 1'b1,
                  $onehot0({cmd.load, cmd.exec, cmd.div_commit, cmd.fill, cmd.publish}))
  `ASSERT_NEXT(a_div_enter, clk, rst, cmd.div_start, state == ST_DIV && !stat.div_done)
  `ASSERT_NEXT(a_publish_valid, clk, rst, cmd.publish, out_valid && state == ST_IDLE)

endmodule

`default_nettype wire

// ===== rtl/core/forth_data_stack_unit.sv =====
// Forth data stack unit: runs one primitive per input beat on a stack of
// signed 32-bit words (STACK_DEPTH entries) and returns one result beat
// with the new top, second, depth, branch flag and status. The top two
// entries live in registers and the rest in a single-port-write memory
// with a registered read. Items are handled one at a time: a stack op
// passes the execute and done states, with a fill state added when a
// pop has to refill the second entry from memory; / and MOD add a divide
// state for the bit-serial divider (one quotient bit per cycle). A
// finished result sits in an output register, so the next item can be
// accepted while it waits. On underflow, overflow or divide by zero the
// stack is left unchanged.
`default_nettype none

module forth_data_stack_unit #(
  parameter int unsigned STACK_DEPTH = fdsu_pkg::STACK_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [fdsu_pkg::MODE_W-1:0]         mode,
  input  logic signed [fdsu_pkg::DATA_W-1:0]  literal,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fdsu_pkg::DATA_W-1:0]  top,
  output logic signed [fdsu_pkg::DATA_W-1:0]  second,
  output logic [fdsu_pkg::DEPTH_W-1:0]        depth,
  output logic                                branch_taken,
  output logic [1:0]                          status
);
  import fdsu_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  fdsu_control u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // stack, alu, divider and result register
  fdsu_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .mode         (mode),
    .literal      (literal),
    .top          (top),
    .second       (second),
    .depth        (depth),
    .branch_taken (branch_taken),
    .status       (status)
  );

endmodule

`default_nettype wire

// ===== sim/tb_forth_data_stack_unit.sv =====
module tb_forth_data_stack_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fdsu_pkg::*;

  localparam int unsigned CAPACITY     = STACK_DEPTH_DEF;
  localparam int          RANDOM_ITEMS = 1100;
  localparam int          LIMIT_CYCLES = 400000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 60;
  localparam int          PRINT_CAP    = 50;

  // modes outside the primitive set
  localparam mode_t OP_UNUSED_FIRST = 5'd24;
  localparam mode_t OP_UNUSED_LAST  = 5'd31;

  localparam logic [31:0] WORD_MIN      = 32'h8000_0000;
  localparam logic [31:0] WORD_MAX      = 32'h7fff_ffff;
  localparam logic [31:0] WORD_ALL_ONES = 32'hffff_ffff;

  typedef struct packed {
    mode_t       op;
    logic [31:0] arg;
  } prim_t;

  typedef struct {
    logic [31:0] top;
    logic [31:0] second;
    logic [6:0]  depth;
    logic        taken;
    status_t     status;
  } stack_view_t;

  typedef enum {WALK_UP, WALK_DOWN, WALK_EVEN} walk_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  mode_t              mode = OP_LIT;
  logic signed [31:0] literal = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] top;
  logic signed [31:0] second;
  logic [6:0]         depth;
  logic               branch_taken;
  logic [1:0]         status;

  forth_data_stack_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .literal      (literal),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .top          (top),
    .second       (second),
    .depth        (depth),
    .branch_taken (branch_taken),
    .status       (status)
  );

  // pending primitives and expected stack views
  prim_t       prim_queue[$];
  stack_view_t stack_results[$];
  prim_t       next_prim;
  stack_view_t want;

  // shadow stack
  logic [31:0] stack_mem [0:CAPACITY-1];
  int unsigned stack_count = 0;
  int unsigned gen_depth = 0;

  int  errors = 0;
  int  sent_beats = 0;
  int  checked_beats = 0;
  int  cycle_count = 0;
  int  blocked_cycles = 0;
  int  idle_phase = 0;
  logic hold_off = 1'b0;

  // coverage tallies
  int  peak_depth = 0;
  int  under_count = 0;
  int  over_count = 0;
  int  divz_count = 0;
  int  divide_count = 0;
  int  taken_count = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= PRINT_CAP) $display("mismatch at result %0d: %s", checked_beats, what);
  endtask

  function automatic void push_word(logic [31:0] w);
    stack_mem[stack_count] = w;
    stack_count++;
    if (stack_count > peak_depth) peak_depth = stack_count;
  endfunction

  // binary ops replace the top two entries with one
  function automatic void fold_pair(logic [31:0] r);
    stack_count--;
    stack_mem[stack_count-1] = r;
  endfunction

  // execute one primitive on the shadow stack
  function automatic stack_view_t apply_primitive(mode_t m, logic [31:0] lit);
    int unsigned need;
    logic        grow;
    logic [31:0] a, b, mag_a, mag_b, r;
    stack_view_t v;
    need = 0;
    grow = 1'b0;
    v.taken = 1'b0;
    v.status = STAT_OK;
    if (m <= OP_ONE) begin
      need = (m == OP_DUP || m == OP_DROP) ? 1 : (m == OP_SWAP || m == OP_OVER) ? 2 : 0;
      grow = !(m == OP_DROP || m == OP_SWAP);
    end else if (m <= OP_LE) begin
      need = 2;
    end else if (m <= OP_ZBRANCH) begin
      need = 1;
    end
    b = (stack_count >= 1) ? stack_mem[stack_count-1] : '0;
    a = (stack_count >= 2) ? stack_mem[stack_count-2] : '0;
    mag_a = a[31] ? -a : a;
    mag_b = b[31] ? -b : b;

    if (stack_count < need) begin
      v.status = STAT_UNDER;
      under_count++;
    end else if (grow && stack_count >= CAPACITY) begin
      v.status = STAT_OVER;
      over_count++;
    end else if ((m == OP_DIV || m == OP_MOD) && b == '0) begin
      v.status = STAT_DIVZ;
      divz_count++;
    end else begin
      case (m)
        OP_LIT:  push_word(lit);
        OP_DUP:  push_word(b);
        OP_DROP: stack_count--;
        OP_SWAP: begin
          stack_mem[stack_count-1] = a;
          stack_mem[stack_count-2] = b;
        end
        OP_OVER: push_word(a);
        OP_ZERO: push_word(32'd0);
        OP_ONE:  push_word(32'd1);
        OP_ADD:  fold_pair(a + b);
        OP_SUB:  fold_pair(a - b);
        OP_MUL:  fold_pair(a * b);
        OP_DIV: begin
          // truncate toward zero, sign from both operands
          r = mag_a / mag_b;
          if (a[31] ^ b[31]) r = 32'd0 - r;
          fold_pair(r);
          divide_count++;
        end
        OP_MOD: begin
          // remainder follows the dividend
          r = mag_a % mag_b;
          if (a[31]) r = 32'd0 - r;
          fold_pair(r);
          divide_count++;
        end
        OP_EQ:   fold_pair({31'd0, $signed(a) == $signed(b)});
        OP_NE:   fold_pair({31'd0, $signed(a) != $signed(b)});
        OP_GT:   fold_pair({31'd0, $signed(a) > $signed(b)});
        OP_GE:   fold_pair({31'd0, $signed(a) >= $signed(b)});
        OP_LT:   fold_pair({31'd0, $signed(a) < $signed(b)});
        OP_LE:   fold_pair({31'd0, $signed(a) <= $signed(b)});
        OP_ZEQ:  stack_mem[stack_count-1] = {31'd0, $signed(b) == 0};
        OP_ZNE:  stack_mem[stack_count-1] = {31'd0, $signed(b) != 0};
        OP_ZGT:  stack_mem[stack_count-1] = {31'd0, $signed(b) > 0};
        OP_ZLT:  stack_mem[stack_count-1] = {31'd0, $signed(b) < 0};
        OP_ZBRANCH: begin
          stack_count--;
          v.taken = (stack_mem[stack_count] == '0);
        end
        OP_BRANCH: v.taken = 1'b1;
        default: ;
      endcase
    end
    if (v.taken) taken_count++;

    v.top    = (stack_count >= 1) ? stack_mem[stack_count-1] : '0;
    v.second = (stack_count >= 2) ? stack_mem[stack_count-2] : '0;
    v.depth  = stack_count[6:0];
    return v;
  endfunction

  // queue a primitive and track the rough depth it leads to
  function automatic void add_prim(mode_t m, logic [31:0] w);
    prim_queue.push_back('{op: m, arg: w});
    case (m)
      OP_LIT, OP_ZERO, OP_ONE: if (gen_depth < CAPACITY) gen_depth++;
      OP_DUP:  if (gen_depth >= 1 && gen_depth < CAPACITY) gen_depth++;
      OP_OVER: if (gen_depth >= 2 && gen_depth < CAPACITY) gen_depth++;
      OP_DROP, OP_ZBRANCH: if (gen_depth >= 1) gen_depth--;
      default: if (m >= OP_ADD && m <= OP_LE && gen_depth >= 2) gen_depth--;
    endcase
  endfunction

  // idling mix per phase: none, sender, receiver, both
  function automatic int send_idle_pct(int ph);
    return (ph == 1) ? 58 : (ph == 3) ? 14 : 0;
  endfunction

  function automatic int recv_stall_pct(int ph);
    return (ph == 2) ? 58 : (ph == 3) ? 14 : 0;
  endfunction

  // driver: present the next primitive whenever the beat is free
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        stack_results.push_back(apply_primitive(mode, literal));
        sent_beats++;
      end
      if (in_valid && in_stall) blocked_cycles++;
      if (!in_valid || !in_stall) begin
        if (prim_queue.size() > 0 &&
            (hold_off || $urandom_range(99) >= send_idle_pct(idle_phase))) begin
          next_prim = prim_queue.pop_front();
          mode     <= next_prim.op;
          literal  <= next_prim.arg;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      idle_phase <= (sent_beats / 128) % 4;
    end
  end

  // monitor: compare each result beat with the oldest expected view
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (stack_results.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = stack_results.pop_front();
          if (top !== want.top)
            report_mismatch($sformatf("top %h expected %h", top, want.top));
          if (second !== want.second)
            report_mismatch($sformatf("second %h expected %h", second, want.second));
          if (depth !== want.depth)
            report_mismatch($sformatf("depth %0d expected %0d", depth, want.depth));
          if (branch_taken !== want.taken)
            report_mismatch($sformatf("branch_taken %b expected %b", branch_taken, want.taken));
          if (status !== want.status)
            report_mismatch($sformatf("status %0d expected %0d", status, want.status));
        end
        checked_beats++;
      end
      out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct(idle_phase));
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (sent_beats >= 400);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, stack_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    walk_t       walk;
    int          burst;
    int          known;
    int          push_pct;
    int          pick;
    mode_t       m;
    logic [31:0] w;

    // directed: empty-stack faults, branch, unknown mode, wrap, division corners
    add_prim(OP_DROP, '0);
    add_prim(OP_ZBRANCH, '0);
    add_prim(OP_BRANCH, WORD_ALL_ONES);
    add_prim(OP_UNUSED_LAST, WORD_ALL_ONES);
    add_prim(OP_LIT, WORD_MAX);
    add_prim(OP_ONE, '0);
    add_prim(OP_ADD, '0);
    add_prim(OP_LIT, WORD_ALL_ONES);
    add_prim(OP_DIV, '0);
    add_prim(OP_LIT, WORD_ALL_ONES);
    add_prim(OP_MOD, '0);
    add_prim(OP_ZERO, '0);
    add_prim(OP_DIV, '0);
    add_prim(OP_MOD, '0);
    add_prim(OP_LIT, -32'sd7);
    add_prim(OP_LIT, 32'd2);
    add_prim(OP_SWAP, '0);
    add_prim(OP_OVER, '0);
    add_prim(OP_MOD, '0);
    add_prim(OP_DIV, '0);
    add_prim(OP_MUL, '0);
    add_prim(OP_ZEQ, '0);
    add_prim(OP_ZBRANCH, '0);
    add_prim(OP_ZBRANCH, '0);
    add_prim(OP_SWAP, '0);

    // random walks: climb to full, wander, drain to empty
    walk = WALK_UP;
    burst = 0;
    known = 0;
    while (known < RANDOM_ITEMS) begin
      push_pct = (walk == WALK_UP) ? 65 : (walk == WALK_DOWN) ? 15 : 35;
      pick = $urandom_range(99);
      if (pick < 3) begin
        m = mode_t'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      end else if (pick < 3 + push_pct) begin
        case ($urandom_range(8))
          5:       m = OP_DUP;
          6:       m = OP_OVER;
          7:       m = OP_ZERO;
          8:       m = OP_ONE;
          default: m = OP_LIT;
        endcase
      end else begin
        pick = $urandom_range(18);
        if (pick == 17) m = OP_DROP;
        else if (pick == 18) m = OP_SWAP;
        else m = mode_t'(OP_ADD + pick);
      end
      case ($urandom_range(9))
        0:       w = '0;
        1:       w = 32'd1;
        2:       w = WORD_ALL_ONES;
        3:       w = WORD_MIN;
        4:       w = WORD_MAX;
        5, 6:    w = $urandom_range(20) - 10;
        default: w = $urandom;
      endcase
      add_prim(m, w);
      if (m <= OP_BRANCH) known++;

      case (walk)
        WALK_UP: if (gen_depth >= CAPACITY && $urandom_range(11) == 0) begin
          walk = WALK_EVEN;
          burst = $urandom_range(30, 90);
        end
        WALK_DOWN: if (gen_depth == 0 && $urandom_range(5) == 0) begin
          walk = WALK_EVEN;
          burst = $urandom_range(30, 90);
        end
        default: begin
          burst--;
          if (burst <= 0) walk = $urandom_range(1) ? WALK_UP : WALK_DOWN;
        end
      endcase
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (prim_queue.size() > 0 || in_valid) @(posedge clk);
    while (stack_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results, peak depth %0d, faults: %0d underflow %0d overflow %0d div0",
             checked_beats, peak_depth, under_count, over_count, divz_count);
    $display("%0d divides, %0d branches taken, input back-pressured for %0d cycles",
             divide_count, taken_count, blocked_cycles);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
